[rtl/core/tlfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfs_pkg
// Shared types, constants and helpers of the TDM link failsafe supervisor.
// ----------------------------------------------------------------------------
package tlfs_pkg;

   localparam int TickWidth   = 32;
   localparam int HopWidth    = 16;
   localparam int CountWidth  = 16;
   localparam int ByteWidth   = 8;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam int DivSteps    = TickWidth;
   localparam int DivCntWidth = $clog2(DivSteps + 1);

   localparam logic [CountWidth-1:0] CountSat   = '1;
   localparam logic [CountWidth-1:0] MaxPwrMisses = 16'd2;

   typedef enum logic [1:0] {
      LINK_DISCONNECTED = 2'd0,
      LINK_CONNECTING   = 2'd1,
      LINK_CONNECTED    = 2'd2,
      LINK_FAILSAFE     = 2'd3
   } link_state_type;

   typedef enum logic [1:0] {
      SLOT_SYNC   = 2'd0,
      SLOT_TLM    = 2'd1,
      SLOT_UPLINK = 2'd2
   } slot_type_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_HOP,
      SEQ_POS,
      SEQ_RATIO,
      SEQ_DONE
   } seq_state_type;

   localparam logic [2:0] CSR_ROLE      = 3'd0;
   localparam logic [2:0] CSR_HOP       = 3'd1;
   localparam logic [2:0] CSR_SEQ_LEN   = 3'd2;
   localparam logic [2:0] CSR_TLM_RATIO = 3'd3;
   localparam logic [2:0] CSR_FS_MISSES = 3'd4;
   localparam logic [2:0] CSR_TLM_GRACE = 3'd5;
   localparam logic [2:0] CSR_UP_GRACE  = 3'd6;
   localparam logic [2:0] CSR_BENCH     = 3'd7;

   localparam logic                  RstRole     = 1'b0;
   localparam logic [HopWidth-1:0]   RstHop      = 16'd1;
   localparam logic [ByteWidth-1:0]  RstSeqLen   = 8'd80;
   localparam logic [ByteWidth-1:0]  RstTlmRatio = 8'd4;
   localparam logic [ByteWidth-1:0]  RstFsMisses = 8'd10;
   localparam logic [ByteWidth-1:0]  RstTlmGrace = 8'd4;
   localparam logic [ByteWidth-1:0]  RstUpGrace  = 8'd4;
   localparam logic                  RstBench    = 1'b0;

   typedef struct packed {
      logic                 role_is_receiver;
      logic [HopWidth-1:0]  hop_interval;
      logic [ByteWidth-1:0] sequence_length;
      logic [ByteWidth-1:0] telemetry_ratio;
      logic [ByteWidth-1:0] failsafe_misses;
      logic [ByteWidth-1:0] telemetry_grace;
      logic [ByteWidth-1:0] uplink_grace;
      logic                 bench_mode;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [TickWidth-1:0] dividend;
      logic [HopWidth-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [TickWidth-1:0] quotient;
      logic [HopWidth-1:0]  remainder;
   } div_res_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      return (v == CountSat) ? v : v + CountWidth'(1);
   endfunction

endpackage

[rtl/core/tlfs_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfs_req_if
// End-of-tick event channel: valid/ready plus the slot item payload.
// ----------------------------------------------------------------------------
interface tlfs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] tx_tick;
   logic        hop_locked;
   logic        sync_seen;
   logic        ever_received;
   logic        got_rc;
   logic        got_sync;
   logic        got_tlm;
   logic        got_valid_uplink;
   logic        got_valid_telemetry;
   logic        downlink_quality_nonzero;

   modport source (
      output valid, tx_tick, hop_locked, sync_seen, ever_received, got_rc, got_sync,
             got_tlm, got_valid_uplink, got_valid_telemetry, downlink_quality_nonzero,
      input  ready
   );

   modport sink (
      input  valid, tx_tick, hop_locked, sync_seen, ever_received, got_rc, got_sync,
             got_tlm, got_valid_uplink, got_valid_telemetry, downlink_quality_nonzero,
      output ready
   );
endinterface

[rtl/core/tlfs_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfs_rsp_if
// Slot result channel: valid/ready plus link state and request flags.
// ----------------------------------------------------------------------------
interface tlfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  link_state;
   logic [1:0]  slot_type;
   logic        max_power_request;
   logic        timing_reset_request;
   logic [15:0] telemetry_miss_total;

   modport source (
      output valid, link_state, slot_type, max_power_request, timing_reset_request,
             telemetry_miss_total,
      input  ready
   );

   modport sink (
      input  valid, link_state, slot_type, max_power_request, timing_reset_request,
             telemetry_miss_total,
      output ready
   );
endinterface

[rtl/core/tlfs_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfs_csr
// APB register file holding the supervisor configuration.
// ----------------------------------------------------------------------------
module tlfs_csr
   import tlfs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CsrAddrWidth-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_ROLE:      cfg_in.role_is_receiver = pwdata[0];
            CSR_HOP:       cfg_in.hop_interval     = pwdata[HopWidth-1:0];
            CSR_SEQ_LEN:   cfg_in.sequence_length  = pwdata[ByteWidth-1:0];
            CSR_TLM_RATIO: cfg_in.telemetry_ratio  = pwdata[ByteWidth-1:0];
            CSR_FS_MISSES: cfg_in.failsafe_misses  = pwdata[ByteWidth-1:0];
            CSR_TLM_GRACE: cfg_in.telemetry_grace  = pwdata[ByteWidth-1:0];
            CSR_UP_GRACE:  cfg_in.uplink_grace     = pwdata[ByteWidth-1:0];
            CSR_BENCH:     cfg_in.bench_mode       = pwdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.role_is_receiver <= RstRole;
         cfg_ff.hop_interval     <= RstHop;
         cfg_ff.sequence_length  <= RstSeqLen;
         cfg_ff.telemetry_ratio  <= RstTlmRatio;
         cfg_ff.failsafe_misses  <= RstFsMisses;
         cfg_ff.telemetry_grace  <= RstTlmGrace;
         cfg_ff.uplink_grace     <= RstUpGrace;
         cfg_ff.bench_mode       <= RstBench;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_ROLE:      prdata = CsrDataWidth'(cfg_ff.role_is_receiver);
         CSR_HOP:       prdata = CsrDataWidth'(cfg_ff.hop_interval);
         CSR_SEQ_LEN:   prdata = CsrDataWidth'(cfg_ff.sequence_length);
         CSR_TLM_RATIO: prdata = CsrDataWidth'(cfg_ff.telemetry_ratio);
         CSR_FS_MISSES: prdata = CsrDataWidth'(cfg_ff.failsafe_misses);
         CSR_TLM_GRACE: prdata = CsrDataWidth'(cfg_ff.telemetry_grace);
         CSR_UP_GRACE:  prdata = CsrDataWidth'(cfg_ff.uplink_grace);
         CSR_BENCH:     prdata = CsrDataWidth'(cfg_ff.bench_mode);
      endcase
   end

endmodule

[rtl/core/tlfs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlfs_div
   import tlfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   logic [TickWidth-1:0]   dvd_ff, dvd_in;
   logic [HopWidth-1:0]    rem_ff, rem_in;
   logic [HopWidth-1:0]    dsr_ff, dsr_in;
   logic [DivCntWidth-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [HopWidth:0]      rem_shift;
   logic                   fits;

   assign rem_shift = {rem_ff, dvd_ff[TickWidth-1]};
   assign fits      = rem_shift >= {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         rem_in  = '0;
         cnt_in  = DivCntWidth'(DivSteps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? HopWidth'(rem_shift - {1'b0, dsr_ff}) : rem_shift[HopWidth-1:0];
         dvd_in = {dvd_ff[TickWidth-2:0], fits};
         cnt_in = cnt_ff - DivCntWidth'(1);
         if (cnt_ff == DivCntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = dvd_ff;
   assign res.remainder = rem_ff;

endmodule

[rtl/core/tlfs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfs_ctrl
// Slot sequencer: drives the divider passes, then updates counters and link state.
// ----------------------------------------------------------------------------
module tlfs_ctrl
   import tlfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   tlfs_req_if.sink          req_ch,
   tlfs_rsp_if.source        rsp_ch,
   output div_cmd_type       div_cmd,
   input  div_res_type       div_res
);

   seq_state_type seq_ff, seq_in;

   // latched item
   logic [TickWidth-1:0] tick_ff;
   logic locked_ff, sync_seen_ff, ever_rx_ff, g_rc_ff, g_sync_ff, g_tlm_ff;
   logic g_vup_ff, g_vtlm_ff, dq_nz_ff;
   logic pos_zero_ff, pos_zero_in;
   logic tlm_hit_ff, tlm_hit_in;

   // link state
   link_state_type        link_ff, link_in;
   logic [CountWidth-1:0] miss_up_ff, miss_up_in;
   logic [CountWidth-1:0] miss_tlm_ff, miss_tlm_in;
   logic [ByteWidth-1:0]  up_grace_ff, up_grace_in;
   logic [ByteWidth-1:0]  tlm_grace_ff, tlm_grace_in;
   logic [CountWidth-1:0] tlm_sum_ff, tlm_sum_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   link_state_type        rsp_link_ff;
   slot_type_type         rsp_slot_ff;
   logic                  rsp_maxpwr_ff, rsp_treset_ff;
   logic [CountWidth-1:0] rsp_sum_ff;

   logic accept, commit, out_free;
   logic [HopWidth-1:0]  hop_eff;
   logic [ByteWidth-1:0] len_eff, ratio_eff;
   slot_type_type         slot;
   logic rx, tx, got, link_valid, rejoin, maxpwr, treset;
   logic [CountWidth-1:0] misses;

   assign accept   = req_ch.valid & req_ch.ready;
   assign out_free = ~rsp_valid_ff | rsp_ch.ready;
   assign hop_eff   = (cfg.hop_interval == '0) ? HopWidth'(1) : cfg.hop_interval;
   assign len_eff   = (cfg.sequence_length == '0) ? ByteWidth'(1) : cfg.sequence_length;
   assign ratio_eff = (cfg.telemetry_ratio == '0) ? ByteWidth'(1) : cfg.telemetry_ratio;

   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_IDLE:  if (req_ch.valid) seq_in = SEQ_HOP;
         SEQ_HOP:   if (div_res.done) seq_in = SEQ_POS;
         SEQ_POS:   if (div_res.done) seq_in = SEQ_RATIO;
         SEQ_RATIO: if (div_res.done) seq_in = SEQ_DONE;
         SEQ_DONE:  if (out_free) seq_in = SEQ_IDLE;
         default:   seq_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready     = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = req_ch.tx_tick;
      div_cmd.divisor  = hop_eff;
      commit           = 1'b0;
      pos_zero_in      = pos_zero_ff;
      tlm_hit_in       = tlm_hit_ff;
      unique case (seq_ff)
         SEQ_IDLE: begin
            req_ch.ready  = ~reset;
            div_cmd.start = req_ch.valid & ~reset;
         end
         SEQ_HOP: begin
            div_cmd.start    = div_res.done;
            div_cmd.dividend = div_res.quotient;
            div_cmd.divisor  = HopWidth'(len_eff);
         end
         SEQ_POS: begin
            div_cmd.start    = div_res.done;
            div_cmd.dividend = tick_ff;
            div_cmd.divisor  = HopWidth'(ratio_eff);
            if (div_res.done) pos_zero_in = (div_res.remainder == '0);
         end
         SEQ_RATIO: begin
            if (div_res.done) begin
               tlm_hit_in = (div_res.remainder == '0) && (cfg.telemetry_ratio != '0);
            end
         end
         SEQ_DONE: begin
            commit = out_free;
         end
         default: begin
         end
      endcase
   end

   // slot update
   always_comb begin
      rx   = cfg.role_is_receiver;
      tx   = ~cfg.role_is_receiver;
      slot = pos_zero_ff ? SLOT_SYNC : (tlm_hit_ff ? SLOT_TLM : SLOT_UPLINK);

      miss_up_in   = miss_up_ff;
      miss_tlm_in  = miss_tlm_ff;
      up_grace_in  = up_grace_ff;
      tlm_grace_in = tlm_grace_ff;
      tlm_sum_in   = tlm_sum_ff;
      link_in      = link_ff;
      maxpwr       = 1'b0;

      if (tx && slot == SLOT_TLM) begin
         if (tlm_grace_ff != '0) begin
            tlm_grace_in = g_vtlm_ff ? '0 : tlm_grace_ff - ByteWidth'(1);
            miss_tlm_in  = '0;
         end else if (g_vtlm_ff) begin
            miss_tlm_in = '0;
         end else begin
            miss_tlm_in = sat_inc(miss_tlm_ff);
            tlm_sum_in  = sat_inc(tlm_sum_ff);
            maxpwr      = miss_tlm_in >= MaxPwrMisses;
         end
      end

      got        = g_rc_ff | g_sync_ff | g_vup_ff | g_vtlm_ff;
      link_valid = cfg.bench_mode ? (g_vtlm_ff | g_tlm_ff) : got;

      if (rx && locked_ff && slot == SLOT_UPLINK) begin
         if (up_grace_ff != '0) begin
            up_grace_in = g_vup_ff ? '0 : up_grace_ff - ByteWidth'(1);
            miss_up_in  = '0;
         end else if (got) begin
            miss_up_in = '0;
         end else begin
            miss_up_in = sat_inc(miss_up_ff);
         end
      end else if (got) begin
         miss_up_in = '0;
      end

      if (rx) misses = miss_up_in;
      else if (ever_rx_ff) misses = miss_tlm_in;
      else misses = CountWidth'(cfg.failsafe_misses) + CountWidth'(1);
      if (cfg.bench_mode && tx && dq_nz_ff) misses = '0;

      rejoin = rx ? (locked_ff & sync_seen_ff & g_rc_ff) : link_valid;
      if (link_ff == LINK_CONNECTED) begin
         if (misses >= CountWidth'(cfg.failsafe_misses)) link_in = LINK_FAILSAFE;
      end else if (rejoin) begin
         link_in = LINK_CONNECTED;
      end

      if (link_in == LINK_CONNECTED && link_ff != LINK_CONNECTED) begin
         if (rx) up_grace_in = cfg.uplink_grace;
         else tlm_grace_in = cfg.telemetry_grace;
      end

      treset = rx && link_ff == LINK_CONNECTED && link_in == LINK_FAILSAFE && !locked_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         link_ff      <= LINK_CONNECTING;
         miss_up_ff   <= '0;
         miss_tlm_ff  <= '0;
         up_grace_ff  <= '0;
         tlm_grace_ff <= '0;
         tlm_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            link_ff      <= link_in;
            miss_up_ff   <= miss_up_in;
            miss_tlm_ff  <= miss_tlm_in;
            up_grace_ff  <= up_grace_in;
            tlm_grace_ff <= tlm_grace_in;
            tlm_sum_ff   <= tlm_sum_in;
         end
      end
      pos_zero_ff <= pos_zero_in;
      tlm_hit_ff  <= tlm_hit_in;
      if (accept) begin
         tick_ff      <= req_ch.tx_tick;
         locked_ff    <= req_ch.hop_locked;
         sync_seen_ff <= req_ch.sync_seen;
         ever_rx_ff   <= req_ch.ever_received;
         g_rc_ff      <= req_ch.got_rc;
         g_sync_ff    <= req_ch.got_sync;
         g_tlm_ff     <= req_ch.got_tlm;
         g_vup_ff     <= req_ch.got_valid_uplink;
         g_vtlm_ff    <= req_ch.got_valid_telemetry;
         dq_nz_ff     <= req_ch.downlink_quality_nonzero;
      end
      if (commit) begin
         rsp_link_ff   <= link_in;
         rsp_slot_ff   <= slot;
         rsp_maxpwr_ff <= maxpwr;
         rsp_treset_ff <= treset;
         rsp_sum_ff    <= tlm_sum_in;
      end
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.link_state           = rsp_link_ff;
   assign rsp_ch.slot_type            = rsp_slot_ff;
   assign rsp_ch.max_power_request    = rsp_maxpwr_ff;
   assign rsp_ch.timing_reset_request = rsp_treset_ff;
   assign rsp_ch.telemetry_miss_total = rsp_sum_ff;

endmodule

[rtl/core/tdm_link_failsafe_supervisor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdm_link_failsafe_supervisor
// Per-slot link supervisor: slot classification, miss counters, link FSM.
//
// Usage:
//  req_ch carries one end-of-tick item per slot (tick plus reception flags);
//  rsp_ch returns one result item per accepted item: link state after the
//  slot, slot type, max-power and timing-reset requests, telemetry miss total.
//  The APB port (psel/penable/pwrite/paddr/pwdata) sets role, hop interval,
//  sequence length, telemetry ratio, failsafe threshold, grace counts and
//  bench mode; write only while no item is in flight.
//  Each item takes three passes of the shared restoring divider (tick/hop,
//  position mod sequence length, tick mod telemetry ratio), each 32 steps,
//  then a commit into the output register. One item at a time; req_ch is
//  ready only while the sequencer is idle, so a new item is not accepted
//  until the last one has been committed.
//  A finished result waits in the output register; a new item is accepted
//  while it waits, but its update holds until the receiver takes the old one.
//  Reset: synchronous, active high; registers return to defaults, link state
//  to connecting, all counters to zero.
// ----------------------------------------------------------------------------
module tdm_link_failsafe_supervisor
   import tlfs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   tlfs_req_if.sink                req_ch,
   tlfs_rsp_if.source              rsp_ch,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   cfg_type     cfg;
   div_cmd_type div_cmd;
   div_res_type div_res;

   tlfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tlfs_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   tlfs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .div_cmd (div_cmd),
      .div_res (div_res)
   );

endmodule
